// File: src/cse_pkg.sv
// Shared types and constants for the counting semaphore engine.
package cse_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int QUEUE_DEPTH = 8;
	localparam int THREAD_ID_BITS = 8;
	localparam int SLOT_BITS = $clog2(NUM_SLOTS);
	localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int WADDR_BITS = $clog2(NUM_SLOTS * QUEUE_DEPTH);
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_CREATE  = 3'd0,
		ACT_DESTROY = 3'd1,
		ACT_ENTER   = 3'd2,
		ACT_LEAVE   = 3'd3,
		ACT_STATUS  = 3'd4,
		ACT_GET     = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_READY   = 3'd0,
		ST_IN_USE  = 3'd1,
		ST_ILLEGAL = 3'd2,
		ST_DENIED  = 3'd3,
		ST_MISUSE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_EXEC,
		CTL_HOLD
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture input word, start slot read
		logic commit;   // update slot, register result
		logic out_take; // result word left the block
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;
	} dp_stat_t;
endpackage

// File: src/cse_ctrl.sv
// Controller state machine for the counting semaphore engine.
module cse_ctrl
	import cse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CTL_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = stat.out_full;
		cmd.out_take = stat.out_full && !out_stall;
		case (state_q)
			CTL_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				// result register must be free (or emptying) before commit
				if (!stat.out_full || !out_stall) begin
					cmd.commit = 1'b1;
					state_d = CTL_IDLE;
				end else begin
					state_d = CTL_HOLD;
				end
			end
			CTL_HOLD: begin
				if (!out_stall) begin
					cmd.commit = 1'b1;
					state_d = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end
endmodule

// File: src/cse_dp.sv
// Datapath for the counting semaphore engine: slot table, wait queues, result word.
module cse_dp
	import cse_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	input  logic [2:0]                action,
	input  logic [3:0]                slot_index,
	input  logic [7:0]                caller_thread,
	input  logic [15:0]               initial_value,
	input  logic                      shared_flag,
	output logic [2:0]                status,
	output logic                      wake_valid,
	output logic [7:0]                wake_thread,
	output logic                      caller_blocked
);
	// slot table and waiter memories, undefined until create or enqueue writes them
	logic [15:0]               count_mem [NUM_SLOTS];
	logic [15:0]               init_mem [NUM_SLOTS];
	logic [THREAD_ID_BITS-1:0] creator_mem [NUM_SLOTS];
	logic                      shared_mem [NUM_SLOTS];
	logic [THREAD_ID_BITS-1:0] waiter_mem [NUM_SLOTS*QUEUE_DEPTH];
	// control state per slot, in flip-flops
	logic [NUM_SLOTS-1:0]      valid_q;
	logic [QPTR_BITS-1:0]      head_q [NUM_SLOTS];
	logic [FILL_BITS-1:0]      fill_q [NUM_SLOTS];

	// captured request
	logic [2:0]                act_q;
	logic                      range_ok_q;
	logic [SLOT_BITS-1:0]      slot_q;
	logic [THREAD_ID_BITS-1:0] who_q;
	logic [15:0]               ival_q;
	logic                      shr_q;
	// registered reads
	logic [15:0]               cnt_r, ini_r;
	logic [THREAD_ID_BITS-1:0] cre_r, wtr_r;
	logic                      shr_r;

	logic [SLOT_BITS-1:0]      rd_slot;
	logic [QPTR_BITS-1:0]      rd_head;
	logic [WADDR_BITS-1:0]     rd_waddr;
	logic                      out_full_q;

	assign rd_slot = SLOT_BITS'(slot_index);
	assign rd_head = head_q[rd_slot];
	assign rd_waddr = WADDR_BITS'({rd_slot, rd_head});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			range_ok_q <= ({28'd0, slot_index} < NUM_SLOTS);
			slot_q <= rd_slot;
			who_q <= caller_thread[THREAD_ID_BITS-1:0];
			ival_q <= initial_value;
			shr_q <= shared_flag;
			cnt_r <= count_mem[rd_slot];
			ini_r <= init_mem[rd_slot];
			cre_r <= creator_mem[rd_slot];
			shr_r <= shared_mem[rd_slot];
			wtr_r <= waiter_mem[rd_waddr];
		end
	end

	// decision
	logic                 sv, may, qfull, qempty;
	logic [FILL_BITS-1:0] fill;
	logic [QPTR_BITS-1:0] head;
	status_t              st;
	logic                 wv, blk;
	logic                 w_create, w_free, w_cnt, w_enq, w_deq;
	logic [15:0]          new_cnt;
	logic [QPTR_BITS-1:0] tail;

	assign sv = valid_q[slot_q];
	assign fill = fill_q[slot_q];
	assign head = head_q[slot_q];
	assign qempty = (fill == '0);
	assign qfull = (fill >= FILL_BITS'(QUEUE_DEPTH));
	assign may = shr_r || (cre_r == who_q);
	assign tail = QPTR_BITS'((QUEUE_DEPTH'(0) + head + fill) % QUEUE_DEPTH);

	always_comb begin
		st = ST_ILLEGAL;
		wv = 1'b0;
		blk = 1'b0;
		w_create = 1'b0;
		w_free = 1'b0;
		w_cnt = 1'b0;
		w_enq = 1'b0;
		w_deq = 1'b0;
		new_cnt = cnt_r;
		if (range_ok_q && act_q <= ACT_GET) begin
			if (act_q == ACT_CREATE) begin
				if (sv) st = ST_IN_USE;
				else begin
					w_create = 1'b1;
					st = ST_READY;
				end
			end else if (!sv) begin
				st = ST_ILLEGAL;
			end else if (act_q == ACT_DESTROY) begin
				if (!qempty || cnt_r != ini_r) st = ST_MISUSE;
				else begin
					w_free = 1'b1;
					st = ST_READY;
				end
			end else if (act_q == ACT_ENTER) begin
				if (cnt_r != '0) begin
					w_cnt = 1'b1;
					new_cnt = cnt_r - 16'd1;
					st = ST_READY;
				end else if (qfull) begin
					st = ST_MISUSE;
				end else begin
					w_enq = 1'b1;
					blk = 1'b1;
					st = ST_IN_USE;
				end
			end else if (!may) begin
				st = ST_DENIED;
			end else if (act_q == ACT_LEAVE) begin
				if (qempty) begin
					w_cnt = 1'b1;
					if (cnt_r != COUNT_TOP) new_cnt = cnt_r + 16'd1;
					st = ST_READY;
				end else begin
					w_deq = 1'b1;
					wv = 1'b1;
					st = ST_IN_USE;
				end
			end else if (act_q == ACT_STATUS) begin
				st = (cnt_r != '0) ? ST_READY : ST_IN_USE;
			end else begin
				st = ST_READY;
			end
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (w_create) begin
				count_mem[slot_q] <= ival_q;
				init_mem[slot_q] <= ival_q;
				creator_mem[slot_q] <= who_q;
				shared_mem[slot_q] <= shr_q;
			end else if (w_cnt) begin
				count_mem[slot_q] <= new_cnt;
			end
			if (w_enq) waiter_mem[WADDR_BITS'({slot_q, tail})] <= who_q;
		end
	end

	// slot control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			out_full_q <= 1'b0;
		end else begin
			if (cmd.out_take) out_full_q <= 1'b0;
			if (cmd.commit) begin
				out_full_q <= 1'b1;
				if (w_create) begin
					valid_q[slot_q] <= 1'b1;
					head_q[slot_q] <= '0;
					fill_q[slot_q] <= '0;
				end
				if (w_free) valid_q[slot_q] <= 1'b0;
				if (w_enq) fill_q[slot_q] <= fill + FILL_BITS'(1);
				if (w_deq) begin
					fill_q[slot_q] <= fill - FILL_BITS'(1);
					head_q[slot_q] <= QPTR_BITS'((QUEUE_DEPTH'(0) + head + 1) % QUEUE_DEPTH);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= st;
			wake_valid <= wv;
			wake_thread <= wv ? 8'(wtr_r) : 8'd0;
			caller_blocked <= blk;
		end
	end

	assign stat.out_full = out_full_q;
endmodule

// File: src/counting_semaphore_engine.sv
// Top level of the counting semaphore engine: controller plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | action slot_index caller_thread initial_value
//          |                      | shared_flag
//  out     | out_valid/ out_stall | status wake_valid wake_thread caller_blocked
//
// Each word is first captured while the slot tables are read, then the slot
// is updated and the result register loaded; a new word is taken only after
// that update. The serial read-then-write of the slot memories sets this order.
// Reset clears all slot valid bits and queue pointers; no clearing pass.
// A held result stalls only the update step; the captured word waits.
module counting_semaphore_engine
	import cse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [3:0]  slot_index,
	input  logic [7:0]  caller_thread,
	input  logic [15:0] initial_value,
	input  logic        shared_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        wake_valid,
	output logic [7:0]  wake_thread,
	output logic        caller_blocked
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequence each word: accept, execute, present
	cse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	// hold slot table, wait queues and result word
	cse_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(action), .slot_index(slot_index), .caller_thread(caller_thread),
		.initial_value(initial_value), .shared_flag(shared_flag),
		.status(status), .wake_valid(wake_valid), .wake_thread(wake_thread),
		.caller_blocked(caller_blocked)
	);
endmodule

// File: tb/tb_counting_semaphore_engine.sv
// Testbench for the counting semaphore engine: directed table, random words, predictor.
`timescale 1ns / 100ps

module tb_counting_semaphore_engine;
	import cse_pkg::*;

	localparam int RANDOM_WORDS = 900;
	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [3:0]  slot_index;
	logic [7:0]  caller_thread;
	logic [15:0] initial_value;
	logic        shared_flag;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic        wake_valid;
	logic [7:0]  wake_thread;
	logic        caller_blocked;

	counting_semaphore_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .slot_index(slot_index), .caller_thread(caller_thread),
		.initial_value(initial_value), .shared_flag(shared_flag),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .wake_valid(wake_valid), .wake_thread(wake_thread),
		.caller_blocked(caller_blocked)
	);

	typedef struct packed {
		logic [2:0]  act;
		logic [3:0]  slot;
		logic [7:0]  thread;
		logic [15:0] init;
		logic        shared;
	} request_t;

	typedef struct packed {
		status_t     st;
		logic        woke;
		logic [7:0]  woken;
		logic        blocked;
	} answer_t;

	// directed row: the request, plus an answer typed in when it is obvious
	typedef struct {
		request_t req;
		logic     fixed;
		answer_t  ans;
	} row_t;

	// predictor's own copy of the semaphore table
	logic                  sem_live    [NUM_SLOTS];
	logic [15:0]           sem_count   [NUM_SLOTS];
	logic [15:0]           sem_start   [NUM_SLOTS];
	logic [7:0]            sem_owner   [NUM_SLOTS];
	logic                  sem_shared  [NUM_SLOTS];
	logic [7:0]            sem_waiters [NUM_SLOTS][QUEUE_DEPTH];
	int unsigned           sem_head    [NUM_SLOTS];
	int unsigned           sem_fill    [NUM_SLOTS];

	answer_t expected_answers[$];
	int      mismatches;
	int      idle_cycles;
	logic    wide_open;   // no idling on either side while set

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// apply one request to the predictor and return what the block must answer
	function automatic answer_t semaphore_answer(input request_t r);
		answer_t a;
		int unsigned s;
		int unsigned pos;
		a = '{st: ST_ILLEGAL, woke: 1'b0, woken: 8'd0, blocked: 1'b0};
		s = r.slot;
		if (s >= NUM_SLOTS || r.act > ACT_GET)
			return a;
		if (r.act == ACT_CREATE) begin
			if (sem_live[s]) begin
				a.st = ST_IN_USE;
			end else begin
				sem_live[s] = 1'b1;
				sem_count[s] = r.init;
				sem_start[s] = r.init;
				sem_owner[s] = r.thread;
				sem_shared[s] = r.shared;
				sem_head[s] = 0;
				sem_fill[s] = 0;
				a.st = ST_READY;
			end
		end else if (!sem_live[s]) begin
			a.st = ST_ILLEGAL;
		end else if (r.act == ACT_DESTROY) begin
			if (sem_fill[s] != 0 || sem_count[s] != sem_start[s]) begin
				a.st = ST_MISUSE;
			end else begin
				sem_live[s] = 1'b0;
				a.st = ST_READY;
			end
		end else if (r.act == ACT_ENTER) begin
			if (sem_count[s] > 0) begin
				sem_count[s]--;
				a.st = ST_READY;
			end else if (sem_fill[s] >= QUEUE_DEPTH) begin
				a.st = ST_MISUSE;
			end else begin
				pos = (sem_head[s] + sem_fill[s]) % QUEUE_DEPTH;
				sem_waiters[s][pos] = r.thread;
				sem_fill[s]++;
				a.st = ST_IN_USE;
				a.blocked = 1'b1;
			end
		end else if (!(sem_shared[s] || sem_owner[s] == r.thread)) begin
			a.st = ST_DENIED;
		end else if (r.act == ACT_LEAVE) begin
			if (sem_fill[s] == 0) begin
				if (sem_count[s] != COUNT_TOP)
					sem_count[s]++;
				a.st = ST_READY;
			end else begin
				pos = sem_head[s];
				a.woken = sem_waiters[s][pos];
				a.woke = 1'b1;
				sem_head[s] = (pos + 1) % QUEUE_DEPTH;
				sem_fill[s]--;
				a.st = ST_IN_USE;
			end
		end else if (r.act == ACT_STATUS) begin
			a.st = (sem_count[s] > 0) ? ST_READY : ST_IN_USE;
		end else begin
			a.st = ST_READY;
		end
		return a;
	endfunction

	// hold a word on the input until it is taken, idling first at random
	task automatic send_word(input request_t r, output answer_t a);
		if (!wide_open) begin
			while ($urandom_range(99) < 19) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		action <= r.act;
		slot_index <= r.slot;
		caller_thread <= r.thread;
		initial_value <= r.init;
		shared_flag <= r.shared;
		do
			@(posedge clk);
		while (in_stall);
		a = semaphore_answer(r);
		expected_answers.push_back(a);
	endtask

	// random request, mostly well-formed traffic over a few busy slots
	function automatic request_t random_request();
		request_t r;
		int unsigned pick;
		r.slot = ($urandom_range(99) < 80) ? 4'($urandom_range(3)) : 4'($urandom);
		r.thread = ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 10)      r.act = ACT_CREATE;
		else if (pick < 16) r.act = ACT_DESTROY;
		else if (pick < 48) r.act = ACT_ENTER;
		else if (pick < 78) r.act = ACT_LEAVE;
		else if (pick < 86) r.act = ACT_STATUS;
		else if (pick < 94) r.act = ACT_GET;
		else                r.act = 3'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 50)      r.init = 16'($urandom_range(3));
		else if (pick < 60) r.init = COUNT_TOP - 16'($urandom_range(2));
		else                r.init = 16'($urandom);
		r.shared = 1'($urandom);
		return r;
	endfunction

	// output side: stall at random, check every word taken
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					report("unexpected word, status", status, -1);
				end else begin
					want = expected_answers.pop_front();
					if (status !== want.st) report("status", status, want.st);
					if (wake_valid !== want.woke) report("wake_valid", wake_valid, want.woke);
					if (wake_thread !== want.woken)
						report("wake_thread", wake_thread, want.woken);
					if (caller_blocked !== want.blocked)
						report("caller_blocked", caller_blocked, want.blocked);
				end
			end
			out_stall <= !wide_open && ($urandom_range(99) < 19);
		end
	end

	// watchdog: count cycles in which neither side moves a word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		row_t    rows[$];
		request_t r;
		answer_t  a;
		answer_t  none;
		int       settle;

		wide_open = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_CREATE;
		slot_index = '0;
		caller_thread = '0;
		initial_value = '0;
		shared_flag = 1'b0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			sem_live[s] = 1'b0;
			sem_head[s] = 0;
			sem_fill[s] = 0;
		end
		none = '{st: ST_READY, woke: 1'b0, woken: 8'd0, blocked: 1'b0};

		// directed rows; fixed answers only where they are plain to see
		rows.push_back('{'{ACT_ENTER, 4'd0, 8'd1, 16'd0, 1'b0}, 1'b1,
			'{ST_ILLEGAL, 1'b0, 8'd0, 1'b0}});
		rows.push_back('{'{3'd6, 4'd0, 8'd1, 16'd0, 1'b0}, 1'b1,
			'{ST_ILLEGAL, 1'b0, 8'd0, 1'b0}});
		rows.push_back('{'{3'd7, 4'd15, 8'd255, 16'hFFFF, 1'b1}, 1'b1,
			'{ST_ILLEGAL, 1'b0, 8'd0, 1'b0}});
		rows.push_back('{'{ACT_CREATE, 4'd0, 8'd10, 16'd0, 1'b0}, 1'b1, none});
		rows.push_back('{'{ACT_CREATE, 4'd0, 8'd11, 16'd5, 1'b1}, 1'b1,
			'{ST_IN_USE, 1'b0, 8'd0, 1'b0}});
		for (int i = 0; i < QUEUE_DEPTH + 1; i++)
			rows.push_back('{'{ACT_ENTER, 4'd0, 8'(8'hA0 + i), 16'd0, 1'b0}, 1'b0, none});
		rows.push_back('{'{ACT_LEAVE, 4'd0, 8'd99, 16'd0, 1'b0}, 1'b1,
			'{ST_DENIED, 1'b0, 8'd0, 1'b0}});
		rows.push_back('{'{ACT_STATUS, 4'd0, 8'd10, 16'd0, 1'b0}, 1'b0, none});
		rows.push_back('{'{ACT_LEAVE, 4'd0, 8'd10, 16'd0, 1'b0}, 1'b1,
			'{ST_IN_USE, 1'b1, 8'hA0, 1'b0}});
		rows.push_back('{'{ACT_DESTROY, 4'd0, 8'd10, 16'd0, 1'b0}, 1'b1,
			'{ST_MISUSE, 1'b0, 8'd0, 1'b0}});
		rows.push_back('{'{ACT_CREATE, 4'd15, 8'd255, 16'hFFFF, 1'b1}, 1'b1, none});
		rows.push_back('{'{ACT_LEAVE, 4'd15, 8'd0, 16'd0, 1'b0}, 1'b1, none});
		rows.push_back('{'{ACT_GET, 4'd15, 8'd3, 16'd0, 1'b0}, 1'b1, none});
		rows.push_back('{'{ACT_STATUS, 4'd15, 8'd3, 16'd0, 1'b0}, 1'b1, none});
		rows.push_back('{'{ACT_DESTROY, 4'd15, 8'd7, 16'd0, 1'b0}, 1'b1, none});
		rows.push_back('{'{ACT_GET, 4'd15, 8'd7, 16'd0, 1'b0}, 1'b1,
			'{ST_ILLEGAL, 1'b0, 8'd0, 1'b0}});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the table; check fixed answers against the predictor too
		foreach (rows[i]) begin
			send_word(rows[i].req, a);
			if (rows[i].fixed && a !== rows[i].ans)
				report("table row predicted status", a.st, rows[i].ans.st);
		end

		// hold off until the block has drained
		in_valid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// open a long stretch with no idling on either side
			wide_open = (n >= 300 && n < 450);
			r = random_request();
			send_word(r, a);
		end
		in_valid <= 1'b0;
		wide_open = 1'b0;

		while (expected_answers.size() != 0)
			@(posedge clk);
		settle = 0;
		while (settle < 10) begin
			@(posedge clk);
			settle++;
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// File: filelist.f
src/cse_pkg.sv
src/cse_ctrl.sv
src/cse_dp.sv
src/counting_semaphore_engine.sv
tb/tb_counting_semaphore_engine.sv
